// ===== rtl/ehx_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4/L4 header extractor.
package ehx_pkg;

   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam int ETH_HDR_BYTES = 14;
   localparam int IPV4_MIN_FRAME = 34;
   localparam logic [3:0] IPV4_VERSION = 4'd4;
   localparam logic [3:0] IHL_MIN = 4'd5;
   localparam int TCP_HDR_BYTES = 20;
   localparam int UDP_HDR_BYTES = 8;
   localparam int TCP_FLAGS_OFFSET = 13;
   localparam int L4_OFF_BITS = 7;

   typedef enum logic [1:0] {
      L4_NONE = 2'd0,
      L4_TCP  = 2'd1,
      L4_UDP  = 2'd2
   } l4_kind_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] byte_count;
      logic [15:0]           ether_type;
      logic [7:0]            version_ihl;
      logic [7:0]            protocol_num;
      logic [47:0]           dst_mac;
      logic [47:0]           src_mac;
      logic [15:0]           total_len;
      logic [31:0]           src_ip;
      logic [31:0]           dst_ip;
      logic [31:0]           ports;
      logic [7:0]            flags;
   } frame_rec_type;

   typedef struct packed {
      logic [7:0]  l4_flags;
      logic [15:0] l4_dport;
      logic [15:0] l4_sport;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
      logic [15:0] ipv4_len;
      logic [47:0] eth_src;
      logic [47:0] eth_dst;
      l4_kind_type l4_kind;
      logic        is_ipv4;
      logic        has_eth;
      logic        valid_res;
   } result_type;

   localparam int RSP_DATA_BITS = (($bits(result_type) + 7) / 8) * 8;

   typedef struct packed {
      logic          valid;
      frame_rec_type rec;
   } queue_head_type;

   function automatic logic [L4_OFF_BITS-1:0] l4_offset(input logic [3:0] ihl);
      l4_offset = L4_OFF_BITS'(ETH_HDR_BYTES) + {1'b0, ihl, 2'b00};
   endfunction

endpackage

// ===== rtl/ehx_front.sv =====
// Front end: counts frame bytes and captures header fields into a frame record.
module ehx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output logic                  rec_push,
   output ehx_pkg::frame_rec_type rec_data
);

   localparam int CB = ehx_pkg::COUNT_BITS;

   ehx_pkg::frame_rec_type rec_ff, rec_in, rec_cap;
   logic [CB-1:0] p;
   logic [ehx_pkg::L4_OFF_BITS-1:0] l4_off;
   logic [CB-1:0] l4_start;

   assign p = rec_ff.byte_count;
   assign l4_off = ehx_pkg::l4_offset(rec_ff.version_ihl[3:0]);
   assign l4_start = CB'(l4_off);

   always_comb begin
      rec_cap = rec_ff;
      if (p != ehx_pkg::COUNT_MAX) begin
         if (p < CB'(6)) begin
            rec_cap.dst_mac = {rec_ff.dst_mac[39:0], data_byte};
         end else if (p < CB'(12)) begin
            rec_cap.src_mac = {rec_ff.src_mac[39:0], data_byte};
         end else if (p < CB'(14)) begin
            rec_cap.ether_type = {rec_ff.ether_type[7:0], data_byte};
         end else if (p == CB'(14)) begin
            rec_cap.version_ihl = data_byte;
         end else if (p == CB'(16) || p == CB'(17)) begin
            rec_cap.total_len = {rec_ff.total_len[7:0], data_byte};
         end else if (p == CB'(23)) begin
            rec_cap.protocol_num = data_byte;
         end else if (p >= CB'(26) && p < CB'(30)) begin
            rec_cap.src_ip = {rec_ff.src_ip[23:0], data_byte};
         end else if (p >= CB'(30) && p < CB'(34)) begin
            rec_cap.dst_ip = {rec_ff.dst_ip[23:0], data_byte};
         end
         if (p >= CB'(ehx_pkg::IPV4_MIN_FRAME)) begin
            if (p >= l4_start && p < l4_start + CB'(4)) begin
               rec_cap.ports = {rec_ff.ports[23:0], data_byte};
            end
            if (p == l4_start + CB'(ehx_pkg::TCP_FLAGS_OFFSET)) begin
               rec_cap.flags = data_byte;
            end
         end
         rec_cap.byte_count = p + CB'(1);
      end
   end

   always_comb begin
      rec_in = rec_ff;
      if (byte_accept) begin
         rec_in = last_byte ? '0 : rec_cap;
      end
   end

   assign rec_push = byte_accept && last_byte;
   assign rec_data = rec_cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

endmodule

// ===== rtl/ehx_queue.sv =====
// Short queue of finished frame records between the front and back ends.
module ehx_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ehx_pkg::frame_rec_type push_data,
   input  logic                   pop,
   output logic                   full,
   output ehx_pkg::queue_head_type head
);

   localparam int PB = ehx_pkg::QPTR_BITS;
   localparam int NB = ehx_pkg::QCNT_BITS;

   ehx_pkg::frame_rec_type mem_ff [ehx_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == NB'(ehx_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.rec = mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop = pop && head.valid;

   function automatic logic [PB-1:0] ptr_next(input logic [PB-1:0] ptr);
      ptr_next = (ptr == PB'(ehx_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + PB'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + NB'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NB'(ehx_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff != '0)
      else $error("pushed record not held in queue");
`endif

endmodule

// ===== rtl/ehx_back.sv =====
// Back end: applies the header checks to a frame record and holds the result.
module ehx_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ehx_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ehx_pkg::result_type     rsp_result
);

   localparam int CB = ehx_pkg::COUNT_BITS;

   ehx_pkg::result_type res, res_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] ihl;
   logic [CB-1:0] caplen, l4_start;

   assign caplen = head.rec.byte_count;
   assign ihl = head.rec.version_ihl[3:0];
   assign l4_start = CB'(ehx_pkg::l4_offset(ihl));

   always_comb begin
      res = '0;
      res.l4_kind = ehx_pkg::L4_NONE;
      if (caplen >= CB'(ehx_pkg::ETH_HDR_BYTES)) begin
         res.has_eth = 1'b1;
         res.eth_dst = head.rec.dst_mac;
         res.eth_src = head.rec.src_mac;
         if (head.rec.ether_type == ehx_pkg::ETHERTYPE_IPV4) begin
            res.is_ipv4 = 1'b1;
            if (caplen >= CB'(ehx_pkg::IPV4_MIN_FRAME)
                && head.rec.version_ihl[7:4] == ehx_pkg::IPV4_VERSION
                && ihl >= ehx_pkg::IHL_MIN && caplen >= l4_start) begin
               res.ipv4_len = head.rec.total_len;
               res.src_ip = head.rec.src_ip;
               res.dst_ip = head.rec.dst_ip;
               if (head.rec.protocol_num == ehx_pkg::PROTO_TCP
                   && caplen >= l4_start + CB'(ehx_pkg::TCP_HDR_BYTES)) begin
                  res.l4_kind = ehx_pkg::L4_TCP;
                  res.l4_flags = head.rec.flags;
                  res.l4_sport = head.rec.ports[31:16];
                  res.l4_dport = head.rec.ports[15:0];
                  res.valid_res = 1'b1;
               end else if (head.rec.protocol_num == ehx_pkg::PROTO_UDP
                   && caplen >= l4_start + CB'(ehx_pkg::UDP_HDR_BYTES)) begin
                  res.l4_kind = ehx_pkg::L4_UDP;
                  res.l4_sport = head.rec.ports[31:16];
                  res.l4_dport = head.rec.ports[15:0];
                  res.valid_res = 1'b1;
               end
            end
         end
      end
   end

   assign pop = head.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = res_ff;

endmodule

// ===== rtl/eth_ipv4_l4_header_extractor_unit.sv =====
// Top level of the Ethernet/IPv4/TCP-UDP header extractor.
// One byte request is accepted per clock while the record queue has room.
// A frame's record is queued on its last byte; its result is registered when popped.
// Two finished records can wait in the queue behind the output register.
// Reset clears the byte counter, all captured fields, the queue and the output valid.
module eth_ipv4_l4_header_extractor_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] valid_res, [1] has_eth, [2] is_ipv4, [4:3] l4_kind, [52:5] eth_dst,
   // [100:53] eth_src, [116:101] ipv4_len, [148:117] src_ip,
   // [180:149] dst_ip, [196:181] l4_sport, [212:197] l4_dport,
   // [220:213] l4_flags, upper bits zero.
   output logic [ehx_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic q_full, q_pop, rec_push, byte_accept;
   ehx_pkg::frame_rec_type rec_data;
   ehx_pkg::queue_head_type q_head;
   ehx_pkg::result_type rsp_result;

   assign req_tready = !q_full;
   assign byte_accept = req_tvalid && req_tready;

   ehx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .rec_push    (rec_push),
      .rec_data    (rec_data)
   );

   ehx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_data),
      .pop       (q_pop),
      .full      (q_full),
      .head      (q_head)
   );

   ehx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = ehx_pkg::RSP_DATA_BITS'(rsp_result);

`ifndef SYNTHESIS
   a_valid_implies_ipv4: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result.valid_res |-> rsp_result.has_eth && rsp_result.is_ipv4)
      else $error("valid result without IPv4 header");
   a_kind_matches_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_result.valid_res == (rsp_result.l4_kind != ehx_pkg::L4_NONE))
      else $error("l4 kind disagrees with valid flag");
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> q_head.valid || rsp_tvalid)
      else $error("last byte produced no pending result");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the Ethernet/IPv4/TCP-UDP header extractor.
import ehx_pkg::*;

class header_record_checker;
   bit [COUNT_BITS-1:0] n_bytes;
   bit [15:0]           etype;
   bit [7:0]            ver_ihl;
   bit [7:0]            proto;
   bit [47:0]           dmac;
   bit [47:0]           smac;
   bit [15:0]           tot_len;
   bit [31:0]           sip;
   bit [31:0]           dip;
   bit [31:0]           ports;
   bit [7:0]            flags;
   result_type          pending_records[$];
   int                  errors;
   int                  checked;
   int                  n_tcp;
   int                  n_udp;

   function new();
      clear_frame();
      errors = 0;
      checked = 0;
      n_tcp = 0;
      n_udp = 0;
   endfunction

   function void clear_frame();
      n_bytes = '0;
      etype = '0;
      ver_ihl = '0;
      proto = '0;
      dmac = '0;
      smac = '0;
      tot_len = '0;
      sip = '0;
      dip = '0;
      ports = '0;
      flags = '0;
   endfunction

   function void absorb_byte(bit [7:0] b, bit is_last);
      int unsigned p;
      int unsigned l4;
      int unsigned caplen;
      int unsigned ihl;
      result_type  r;
      p = n_bytes;
      if (p < COUNT_MAX) begin
         if (p < 6) dmac = {dmac[39:0], b};
         else if (p < 12) smac = {smac[39:0], b};
         else if (p < 14) etype = {etype[7:0], b};
         else if (p == 14) ver_ihl = b;
         else if (p == 16 || p == 17) tot_len = {tot_len[7:0], b};
         else if (p == 23) proto = b;
         else if (p >= 26 && p < 30) sip = {sip[23:0], b};
         else if (p >= 30 && p < 34) dip = {dip[23:0], b};
         if (p >= IPV4_MIN_FRAME) begin
            l4 = ETH_HDR_BYTES + 4 * ver_ihl[3:0];
            if (p >= l4 && p < l4 + 4) ports = {ports[23:0], b};
            if (p == l4 + TCP_FLAGS_OFFSET) flags = b;
         end
         n_bytes = n_bytes + 1'b1;
      end
      if (!is_last) return;
      r = '0;
      caplen = n_bytes;
      if (caplen >= ETH_HDR_BYTES) begin
         r.has_eth = 1'b1;
         r.eth_dst = dmac;
         r.eth_src = smac;
         if (etype == ETHERTYPE_IPV4) begin
            r.is_ipv4 = 1'b1;
            ihl = ver_ihl[3:0];
            l4 = ETH_HDR_BYTES + 4 * ihl;
            if (caplen >= IPV4_MIN_FRAME && ver_ihl[7:4] == IPV4_VERSION &&
                ihl >= IHL_MIN && caplen >= l4) begin
               r.ipv4_len = tot_len;
               r.src_ip = sip;
               r.dst_ip = dip;
               if (proto == PROTO_TCP && caplen >= l4 + TCP_HDR_BYTES) begin
                  r.l4_kind = L4_TCP;
                  r.l4_flags = flags;
               end else if (proto == PROTO_UDP && caplen >= l4 + UDP_HDR_BYTES) begin
                  r.l4_kind = L4_UDP;
               end
               if (r.l4_kind != L4_NONE) begin
                  r.l4_sport = ports[31:16];
                  r.l4_dport = ports[15:0];
                  r.valid_res = 1'b1;
               end
            end
         end
      end
      pending_records.push_back(r);
      clear_frame();
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 50)
            $display("%0t: record %0d field %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, checked, name, want, got);
      end
   endfunction

   function void check_record(result_type got);
      result_type want;
      if (pending_records.size() == 0) begin
         errors++;
         $display("%0t: unexpected record: expected none, actual 0x%0h", $time, got);
         return;
      end
      want = pending_records.pop_front();
      compare_field("valid_res", want.valid_res, got.valid_res);
      compare_field("has_eth", want.has_eth, got.has_eth);
      compare_field("is_ipv4", want.is_ipv4, got.is_ipv4);
      compare_field("l4_kind", want.l4_kind, got.l4_kind);
      compare_field("eth_dst", want.eth_dst, got.eth_dst);
      compare_field("eth_src", want.eth_src, got.eth_src);
      compare_field("ipv4_len", want.ipv4_len, got.ipv4_len);
      compare_field("src_ip", want.src_ip, got.src_ip);
      compare_field("dst_ip", want.dst_ip, got.dst_ip);
      compare_field("l4_sport", want.l4_sport, got.l4_sport);
      compare_field("l4_dport", want.l4_dport, got.l4_dport);
      compare_field("l4_flags", want.l4_flags, got.l4_flags);
      if (want.l4_kind == L4_TCP) n_tcp++;
      if (want.l4_kind == L4_UDP) n_udp++;
      checked++;
   endfunction
endclass

module tb_top;
   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   header_record_checker records = new();
   bit                   req_idle_on;
   bit                   rsp_idle_on;
   int                   bytes_sent;
   int                   frames_sent;

   eth_ipv4_l4_header_extractor_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_byte(input bit [7:0] b, input bit is_last);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= is_last;
      do @(posedge clock); while (req_tready !== 1'b1);
      records.absorb_byte(b, is_last);
      bytes_sent++;
      @(negedge clock);
   endtask

   // A negative fill value means random frame content.
   task automatic send_frame(input int unsigned len, input bit [15:0] etype,
                             input bit [7:0] vihl, input bit [7:0] proto, input int fill);
      bit [7:0] frame_buf[$];
      frame_buf = {};
      for (int i = 0; i < len; i++) frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      if (len > 12) frame_buf[12] = etype[15:8];
      if (len > 13) frame_buf[13] = etype[7:0];
      if (len > 14) frame_buf[14] = vihl;
      if (len > 23) frame_buf[23] = proto;
      for (int i = 0; i < len; i++) send_byte(frame_buf[i], i == len - 1);
      frames_sent++;
   endtask

   initial begin
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         int unsigned gap;
         gap = rsp_idle_on ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         records.check_record(result_type'(rsp_tdata[$bits(result_type)-1:0]));
         @(negedge clock);
      end
   end

   initial begin
      int unsigned ihl;
      int unsigned hdr;
      int unsigned len;
      int unsigned pick;
      bit [7:0]    proto;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      bytes_sent = 0;
      frames_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_frame(1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, -1);
      send_frame(13, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, -1);
      send_frame(14, 16'h86DD, 8'h45, PROTO_TCP, -1);
      send_frame(14, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, -1);
      send_frame(33, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, -1);
      send_frame(54, ETHERTYPE_IPV4, 8'h65, PROTO_TCP, -1);
      send_frame(54, ETHERTYPE_IPV4, 8'h44, PROTO_TCP, -1);
      send_frame(60, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, -1);
      send_frame(60, ETHERTYPE_IPV4, 8'h45, 8'd1, -1);
      send_frame(53, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, -1);
      send_frame(41, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, -1);
      send_frame(54, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
      send_frame(54, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'hFF);
      send_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'hFF);
      send_frame(94, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, -1);
      send_frame(48, ETHERTYPE_IPV4, 8'h46, PROTO_UDP, -1);

      while (bytes_sent < 1850) begin
         req_idle_on = ($urandom_range(0, 5) != 0);
         rsp_idle_on = ($urandom_range(0, 5) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            pick = $urandom_range(0, 19);
            proto = (pick < 9) ? PROTO_TCP : (pick < 18) ? PROTO_UDP : 8'($urandom);
            hdr = ETH_HDR_BYTES + 4 * ihl;
            if (proto == PROTO_TCP) hdr += TCP_HDR_BYTES;
            else if (proto == PROTO_UDP) hdr += UDP_HDR_BYTES;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, hdr)
                                               : hdr + $urandom_range(0, 8);
            send_frame(len, ETHERTYPE_IPV4, {IPV4_VERSION, 4'(ihl)}, proto, -1);
         end else begin
            send_frame($urandom_range(1, 80),
                       $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom),
                       8'($urandom), 8'($urandom), -1);
         end
      end
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      rsp_idle_on = 1'b0;

      while (records.pending_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d frames in %0d bytes, including malformed and truncated ones.",
               frames_sent, bytes_sent);
      $display("Checked %0d records: %0d accepted as TCP, %0d accepted as UDP.",
               records.checked, records.n_tcp, records.n_udp);
      if (records.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
